@@ rtl/core/note_event_notation_converter_unit_assert.svh @@
// Assertion macros for the note event notation converter checker.
// Used by nenc_checker; needs a clock named i_clk in the including scope.
`ifndef NOTE_EVENT_NOTATION_CONVERTER_UNIT_ASSERT_SVH
`define NOTE_EVENT_NOTATION_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define NENC_ASSERT_IMPL(lbl, rst_n, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nenc: same-cycle implication failed");

// Next-cycle implication, disabled while reset is held.
`define NENC_ASSERT_NEXT(lbl, rst_n, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nenc: next-cycle implication failed");

// Next-cycle implication that is also checked across reset.
`define NENC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("nenc: post-reset condition failed");

`endif

@@ rtl/core/nenc_pkg.sv @@
// Shared types, constants and lookup functions of the note event converter.
// No dependencies; imported by the controller, the datapath and the top level.
package nenc_pkg;

    // Stream widths and field widths.
    localparam int InDataW  = 32;
    localparam int InUserW  = 2;
    localparam int OutDataW = 40;
    localparam int OutUserW = 1;
    localparam int KeyW     = 4;
    localparam int PitchW   = 7;
    localparam int FaceW    = 4;
    localparam int RatioW   = 8;
    localparam int BaseDurW = 13;
    localparam int DurW     = 21;

    // Default width of the running tuplet count.
    localparam int CountBitsDefault = 24;

    // Accidental codes.
    localparam logic [1:0] AccNone = 2'd0;
    localparam logic [1:0] AccFlat = 2'd1;

    // Face codes that are known.
    localparam logic [FaceW-1:0] FaceWhole = 4'd1;
    localparam logic [FaceW-1:0] Face128th = 4'd8;

    // Tuplet mark codes.
    localparam logic [1:0] MarkNone  = 2'd0;
    localparam logic [1:0] MarkStart = 2'd1;
    localparam logic [1:0] MarkMid   = 2'd2;
    localparam logic [1:0] MarkStop  = 2'd3;

    // Flat alteration in two-bit two's complement.
    localparam logic [1:0] AlterFlat = 2'b11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic dot_step;
        logic mul;
        logic div_step;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dots_zero;
        logic tuplet;
        logic div_last;
        logic out_free;
    } t_status;

    // Base length of a face in divisions at 480 per quarter.
    function automatic logic [BaseDurW-1:0] face_len(input logic [FaceW-1:0] face);
        logic [BaseDurW-1:0] len;
        begin
            case (face)
                4'd1:    len = 13'd1920;
                4'd2:    len = 13'd960;
                4'd3:    len = 13'd480;
                4'd4:    len = 13'd240;
                4'd5:    len = 13'd120;
                4'd6:    len = 13'd60;
                4'd7:    len = 13'd30;
                4'd8:    len = 13'd15;
                default: len = 13'd0;
            endcase
            return len;
        end
    endfunction

    // Black keys within the octave, C as zero.
    function automatic logic is_black(input logic [3:0] pc);
        logic b;
        begin
            case (pc)
                4'd1, 4'd3, 4'd6, 4'd8, 4'd10: b = 1'b1;
                default:                       b = 1'b0;
            endcase
            return b;
        end
    endfunction

    // Natural letter of a pitch class (sharps take the letter below).
    function automatic logic [2:0] letter_of(input logic [3:0] pc);
        logic [2:0] l;
        begin
            case (pc)
                4'd0, 4'd1:   l = 3'd0;
                4'd2, 4'd3:   l = 3'd1;
                4'd4:         l = 3'd2;
                4'd5, 4'd6:   l = 3'd3;
                4'd7, 4'd8:   l = 3'd4;
                4'd9, 4'd10:  l = 3'd5;
                default:      l = 3'd6;
            endcase
            return l;
        end
    endfunction

    // Quotient by twelve through the reciprocal 43/512; exact up to 128.
    function automatic logic [3:0] div12(input logic [7:0] x);
        logic [13:0] p;
        begin
            p = 14'(x) * 14'd43;
            return p[12:9];
        end
    endfunction

endpackage

@@ rtl/core/nenc_ctrl.sv @@
// Sequencing controller of the note event converter.
// Depends on nenc_pkg for the command and status structs.
module nenc_ctrl
    import nenc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOTS,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    // Next state and the commands for this cycle.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DOTS;
                end
            end
            ST_DOTS: begin
                if (!i_status.dots_zero) begin
                    o_cmd.dot_step = 1'b1;
                end else if (i_status.tuplet) begin
                    n_state = ST_SCALE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCALE: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register and the registered input ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == ST_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

@@ rtl/core/nenc_datapath.sv @@
// Datapath of the note event converter: spelling, tuplet count, duration
// arithmetic and the output register. Depends on nenc_pkg.
module nenc_datapath
    import nenc_pkg::*;
#(
    parameter int COUNT_BITS = CountBitsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_cfg_wr_en,
    input  logic [KeyW-1:0]     i_cfg_wr_data,
    input  logic [InDataW-1:0]  i_in_tdata,
    input  logic [InUserW-1:0]  i_in_tuser,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OutDataW-1:0] o_out_tdata,
    output logic [OutUserW-1:0] o_out_tuser
);

    localparam int SumW   = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam int ShiftW = 15;
    localparam int DivCntW = $clog2(DurW);

    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    // Input field unpacking.
    logic              in_is_rest, in_measure_start;
    logic [PitchW-1:0] in_pitch;
    logic [1:0]        in_accidental, in_dots;
    logic [FaceW-1:0]  in_face;
    logic [RatioW-1:0] in_actual, in_normal;

    assign in_is_rest       = i_in_tuser[0];
    assign in_measure_start = i_in_tuser[1];
    assign in_pitch         = i_in_tdata[6:0];
    assign in_accidental    = i_in_tdata[8:7];
    assign in_face          = i_in_tdata[12:9];
    assign in_dots          = i_in_tdata[14:13];
    assign in_actual        = i_in_tdata[22:15];
    assign in_normal        = i_in_tdata[30:23];

    // Registers.
    logic [KeyW-1:0]       r_key;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [FaceW-1:0]      r_unit, n_unit;
    logic [1:0]            r_mark, n_mark;
    logic [2:0]            r_step, n_step;
    logic [1:0]            r_alter, n_alter;
    logic [4:0]            r_octave, n_octave;
    logic [FaceW-1:0]      r_type;
    logic                  r_tuplet;
    logic [RatioW-1:0]     r_actual, r_normal;
    logic [1:0]            r_dots;
    logic [BaseDurW-1:0]   r_dur;
    logic [DurW-1:0]       r_quo;
    logic [RatioW-1:0]     r_rem;
    logic [DivCntW-1:0]    r_div_cnt;
    logic                  r_out_valid;
    logic [OutDataW-1:0]   r_out_tdata;
    logic [OutUserW-1:0]   r_out_tuser;

    // Pitch spelling of the incoming event.
    logic       in_tuplet;
    logic [3:0] oct_q, up_q, pc, up_pc;
    logic [7:0] up;
    logic       use_flat;

    assign in_tuplet = (in_actual != '0) && (in_normal != '0);

    always_comb begin
        up      = 8'(in_pitch) + 8'd1;
        oct_q   = div12(8'(in_pitch));
        up_q    = div12(up);
        pc      = 4'(in_pitch - 7'(oct_q) * 7'd12);
        up_pc   = 4'(up - 8'(up_q) * 8'd12);
        use_flat = (in_accidental == AccFlat) ||
                   (is_black(pc) && (in_accidental == AccNone) && r_key[KeyW-1]);
        n_step   = '0;
        n_alter  = '0;
        n_octave = '0;
        if (!in_is_rest) begin
            if (use_flat) begin
                n_step   = letter_of(up_pc);
                n_alter  = AlterFlat;
                n_octave = 5'(up_q) - 5'd1;
            end else begin
                n_step   = letter_of(pc);
                n_alter  = {1'b0, is_black(pc)};
                n_octave = 5'(oct_q) - 5'd1;
            end
        end
    end

    // Tuplet count update for the incoming event.
    logic [COUNT_BITS-1:0]        cnt0, scaled, sat;
    logic [COUNT_BITS+ShiftW-1:0] wide;
    logic [15:0]                  add;
    logic [SumW-1:0]              sum;

    always_comb begin
        cnt0    = in_measure_start ? '0 : r_count;
        n_unit  = r_unit;
        wide    = '0;
        scaled  = cnt0;
        add     = 16'd1;
        sum     = '0;
        sat     = '0;
        n_count = '0;
        n_mark  = MarkNone;
        if (!in_tuplet) begin
            n_count = '0;
            n_mark  = MarkNone;
        end else if (cnt0 == '0) begin
            n_count = COUNT_BITS'(1);
            n_unit  = in_face;
            n_mark  = MarkStart;
        end else begin
            if (in_face > r_unit) begin
                wide   = (COUNT_BITS+ShiftW)'(cnt0) << (in_face - r_unit);
                scaled = (wide[COUNT_BITS+ShiftW-1:COUNT_BITS] != '0) ?
                         CountMax : wide[COUNT_BITS-1:0];
                n_unit = in_face;
            end else if (r_unit > in_face) begin
                add = 16'd1 << (r_unit - in_face);
            end
            sum = SumW'(scaled) + SumW'(add);
            sat = (sum > SumW'(CountMax)) ? CountMax : sum[COUNT_BITS-1:0];
            if (sat >= COUNT_BITS'(in_actual)) begin
                n_count = '0;
                n_mark  = MarkStop;
            end else begin
                n_count = sat;
                n_mark  = MarkMid;
            end
        end
    end

    // Control state: key register, tuplet state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_count     <= '0;
            r_unit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_key <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_count <= n_count;
                r_unit  <= n_unit;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // One restoring division step: one quotient bit per cycle.
    logic [RatioW:0]   trial;
    logic              q_bit;
    logic [RatioW-1:0] rem_next;

    always_comb begin
        trial    = {r_rem, r_quo[DurW-1]};
        q_bit    = (trial >= {1'b0, r_actual});
        rem_next = q_bit ? RatioW'(trial - {1'b0, r_actual}) : trial[RatioW-1:0];
    end

    // Dot step: times three halves, truncated.
    logic [BaseDurW:0] dot_sum;
    assign dot_sum = {1'b0, r_dur} + {r_dur, 1'b0};

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_step   <= n_step;
            r_alter  <= n_alter;
            r_octave <= n_octave;
            r_mark   <= n_mark;
            r_type   <= ((in_face >= FaceWhole) && (in_face <= Face128th)) ? in_face : '0;
            r_tuplet <= in_tuplet;
            r_actual <= in_actual;
            r_normal <= in_normal;
            r_dots   <= in_dots;
            r_dur    <= face_len(in_face);
        end
        if (i_cmd.dot_step) begin
            r_dur  <= dot_sum[BaseDurW:1];
            r_dots <= r_dots - 2'd1;
        end
        if (i_cmd.mul) begin
            r_quo     <= DurW'(r_dur) * DurW'(r_normal);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo     <= {r_quo[DurW-2:0], q_bit};
            r_rem     <= rem_next;
            r_div_cnt <= r_div_cnt + DivCntW'(1);
        end
        if (i_cmd.emit) begin
            r_out_tdata <= {3'b000, r_mark, r_type,
                            (r_tuplet ? r_quo : DurW'(r_dur)),
                            r_octave, r_alter, r_step};
            r_out_tuser <= r_tuplet;
        end
    end

    // Status back to the controller.
    assign o_status.dots_zero = (r_dots == 2'd0);
    assign o_status.tuplet    = r_tuplet;
    assign o_status.div_last  = (r_div_cnt == DivCntW'(DurW - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = r_out_tdata;
    assign o_out_tuser = r_out_tuser;

endmodule

@@ rtl/core/note_event_notation_converter_unit.sv @@
// Top level of the note event notation converter.
// Instantiates nenc_ctrl and nenc_datapath; depends on nenc_pkg.
//
//   Channel   Direction  Transaction
//   s_axis    in         one note or rest event
//   m_axis    out        one spelled event with duration and tuplet mark
//   i_cfg     in         key signature write into a register
//
// An event goes from acceptance through one dot step per dot and, with a tuplet,
// the multiply by normal and the 21-step bit-serial divider by actual before
// the result is loaded; the controller then returns to idle and takes the next event.
// One event is in work at a time.
// s_axis_tready is high after reset; a stalled m_axis holds the result and the block
// may accept and work the next event behind it, but waits to emit it until the output is free.
module note_event_notation_converter_unit
    import nenc_pkg::*;
#(
    parameter int COUNT_BITS = CountBitsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [KeyW-1:0]     i_cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // pitch[6:0], accidental[8:7], face_value[12:9], dots[14:13],
    // actual_notes[22:15], normal_notes[30:23], zero[31]
    input  logic [InDataW-1:0]  s_axis_tdata,
    // is_rest[0], measure_start[1]
    input  logic [InUserW-1:0]  s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // step_letter[2:0], alter[4:3], octave[9:5], duration[30:10],
    // type_code[34:31], tuplet_mark[36:35], zero[39:37]
    output logic [OutDataW-1:0] m_axis_tdata,
    // time_modified[0]
    output logic [OutUserW-1:0] m_axis_tuser
);

    t_cmd    cmd;
    t_status status;

    // Sequencing.
    nenc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage.
    nenc_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tuser    (s_axis_tuser),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_tdata   (m_axis_tdata),
        .o_out_tuser   (m_axis_tuser)
    );

endmodule

@@ rtl/core/nenc_checker.sv @@
// Port-level checker for the note event notation converter, bound to the top.
// Depends on nenc_pkg and the assertion macro header.
`include "note_event_notation_converter_unit_assert.svh"

module nenc_checker
    import nenc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata,
    input logic [OutUserW-1:0] m_axis_tuser
);

    // A stalled result keeps its payload.
    `NENC_ASSERT_NEXT(a_out_hold, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // One event in work at a time: no acceptance in the cycle after one.
    `NENC_ASSERT_NEXT(a_one_in_work, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Reset leaves the block ready and with no result pending.
    `NENC_ASSERT_NEXT_ALWAYS(a_reset_state, !i_rst_n, s_axis_tready && !m_axis_tvalid)

endmodule

bind note_event_notation_converter_unit nenc_checker u_nenc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/nenc_event_checker.sv @@
// Checker for the note event notation converter: watches both stream channels and the
// key signature port, predicts every result and compares it with what the block emits.
// Depends on nenc_pkg for widths and code constants.
module nenc_event_checker
    import nenc_pkg::*;
#(
    parameter int COUNT_BITS = CountBitsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [KeyW-1:0]     i_cfg_wr_data,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    // pitch, accidental, face_value, dots, actual_notes, normal_notes, zero
    input  logic [InDataW-1:0]  s_axis_tdata,
    // is_rest, measure_start
    input  logic [InUserW-1:0]  s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // step_letter, alter, octave, duration, type_code, tuplet_mark, zero
    input  logic [OutDataW-1:0] m_axis_tdata,
    // time_modified
    input  logic [OutUserW-1:0] m_axis_tuser,
    output int                  o_mismatches,
    output int                  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned CountMax = (64'd1 << COUNT_BITS) - 64'd1;
    // Black keys within the octave, one bit per pitch class with C in bit 0.
    localparam logic [11:0] BlackKeys = 12'h54A;

    typedef struct packed {
        logic [2:0]      step;
        logic [1:0]      alter;
        logic [4:0]      octave;
        logic [DurW-1:0] duration;
        logic [3:0]      type_code;
        logic            time_modified;
        logic [1:0]      mark;
    } spelled_t;

    // Own copy of the key signature and of the tuplet tracking state.
    logic [KeyW-1:0]   key_fifths;
    longint unsigned   tuplet_count;
    logic [FaceW-1:0]  tuplet_unit;
    spelled_t          spelled_q[$];

    function automatic logic [2:0] natural_letter(input logic [3:0] pc);
        return (pc < 4'd5) ? 3'(pc >> 1) : 3'((pc + 4'd1) >> 1);
    endfunction

    function automatic int unsigned base_divisions(input logic [FaceW-1:0] face);
        return (face >= FaceWhole && face <= Face128th) ? (32'd1920 >> (face - 4'd1)) : 32'd0;
    endfunction

    function automatic longint unsigned clip_count(input longint unsigned v);
        return (v > CountMax) ? CountMax : v;
    endfunction

    // Advances the running tuplet count, kept in units of the smallest face of the group.
    function automatic logic [1:0] advance_tuplet(input logic [RatioW-1:0] actual,
                                                  input logic [RatioW-1:0] normal,
                                                  input logic [FaceW-1:0] face);
        longint unsigned add;
        add = 64'd1;
        if (actual == '0 || normal == '0) begin
            tuplet_count = 0;
            return MarkNone;
        end
        if (tuplet_count == 0) begin
            tuplet_count = 1;
            tuplet_unit  = face;
            return MarkStart;
        end
        if (face > tuplet_unit) begin
            tuplet_count = clip_count(tuplet_count << (face - tuplet_unit));
            tuplet_unit  = face;
        end else if (tuplet_unit > face) begin
            add = 64'd1 << (tuplet_unit - face);
        end
        tuplet_count = clip_count(tuplet_count + add);
        if (tuplet_count >= actual) begin
            tuplet_count = 0;
            return MarkStop;
        end
        return MarkMid;
    endfunction

    // Works out the result of one accepted event and updates the tuplet state.
    function automatic spelled_t spell_event(input logic [InDataW-1:0] data,
                                             input logic [InUserW-1:0] user);
        spelled_t          r;
        logic [PitchW-1:0] pitch;
        logic [1:0]        accidental;
        logic [FaceW-1:0]  face;
        logic [1:0]        dots;
        logic [RatioW-1:0] actual;
        logic [RatioW-1:0] normal;
        logic [3:0]        pc;
        logic [7:0]        up;
        logic              use_flat;
        logic              tuplet;
        int unsigned       dur;
        pitch      = data[6:0];
        accidental = data[8:7];
        face       = data[12:9];
        dots       = data[14:13];
        actual     = data[22:15];
        normal     = data[30:23];
        r          = '0;
        tuplet     = (actual != '0) && (normal != '0);

        // Pitch spelling; rests keep letter, alteration and octave at zero.
        if (!user[0]) begin
            pc       = 4'(pitch % 12);
            use_flat = (accidental == AccFlat) ||
                       (BlackKeys[pc] && accidental == AccNone && key_fifths[KeyW-1]);
            if (use_flat) begin
                up       = {1'b0, pitch} + 8'd1;
                r.step   = natural_letter(4'(up % 12));
                r.alter  = AlterFlat;
                r.octave = 5'(up / 12) - 5'd1;
            end else begin
                r.step   = natural_letter(pc);
                r.alter  = {1'b0, BlackKeys[pc]};
                r.octave = 5'(pitch / 12) - 5'd1;
            end
        end

        // Duration: face length, dots, then the tuplet ratio, truncating at each step.
        dur = base_divisions(face);
        for (int i = 0; i < int'(dots); i++)
            dur = (dur * 3) / 2;
        if (tuplet)
            dur = (dur * normal) / actual;
        r.duration      = DurW'(dur);
        r.type_code     = (face >= FaceWhole && face <= Face128th) ? face : 4'd0;
        r.time_modified = tuplet;

        if (user[1])
            tuplet_count = 0;
        r.mark = advance_tuplet(actual, normal, face);
        return r;
    endfunction

    function automatic void count_fault(input string msg);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Results are checked before new events are predicted, so that a transaction on
    // each side in the same cycle is handled in order.
    always @(posedge i_clk) begin : watch
        spelled_t seen;
        spelled_t want;
        if (!i_rst_n) begin
            key_fifths   = '0;
            tuplet_count = 0;
            tuplet_unit  = '0;
            o_mismatches = 0;
            spelled_q.delete();
        end else begin
            if (i_cfg_wr_en)
                key_fifths = i_cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready) begin
                seen.step          = m_axis_tdata[2:0];
                seen.alter         = m_axis_tdata[4:3];
                seen.octave        = m_axis_tdata[9:5];
                seen.duration      = m_axis_tdata[30:10];
                seen.type_code     = m_axis_tdata[34:31];
                seen.mark          = m_axis_tdata[36:35];
                seen.time_modified = m_axis_tuser[0];
                if (spelled_q.size() == 0) begin
                    count_fault("result transaction with no event waiting");
                end else begin
                    want = spelled_q.pop_front();
                    if (seen !== want)
                        count_fault($sformatf({"mismatch: step %0d/%0d alter %0d/%0d ",
                            "octave %0d/%0d duration %0d/%0d type %0d/%0d ",
                            "time_modified %0d/%0d mark %0d/%0d (expected/actual)"},
                            want.step, seen.step, want.alter, seen.alter,
                            want.octave, seen.octave, want.duration, seen.duration,
                            want.type_code, seen.type_code,
                            want.time_modified, seen.time_modified, want.mark, seen.mark));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                spelled_q.push_back(spell_event(s_axis_tdata, s_axis_tuser));
        end
        o_outstanding <= spelled_q.size();
    end

endmodule

@@ bench/tb.sv @@
// Testbench top for the note event notation converter: drives events, key signature
// writes and output back-pressure, and gives the verdict.
// Depends on nenc_pkg, note_event_notation_converter_unit and nenc_event_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nenc_pkg::*;

    localparam int Period       = 8;
    localparam int Phases       = 6;
    localparam int PhaseEvents  = 315;
    localparam int HoldCycles   = 300;
    localparam int DrainLimit   = 2000;
    localparam int SettleCycles = 32;
    localparam int TimeoutNs    = 5_000_000;

    // Accidental codes beyond the ones that the package names.
    localparam logic [1:0] AccOther     = 2'd2;
    localparam logic [1:0] AccOtherHigh = 2'd3;

    typedef struct packed {
        logic              is_rest;
        logic [PitchW-1:0] pitch;
        logic [1:0]        accidental;
        logic [FaceW-1:0]  face;
        logic [1:0]        dots;
        logic [RatioW-1:0] actual;
        logic [RatioW-1:0] normal;
        logic              measure_start;
    } note_event_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [KeyW-1:0]     i_cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic [InUserW-1:0]  s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [OutUserW-1:0] m_axis_tuser;
    int                  mismatches;
    int                  outstanding;

    // Stimulus controls shared with the receiver process.
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    // State of the tuplet group being generated.
    int                group_left = 0;
    logic [RatioW-1:0] group_actual;
    logic [RatioW-1:0] group_normal;
    logic [FaceW-1:0]  group_face;

    note_event_t directed_events[$];
    logic [KeyW-1:0] key_plan[Phases] = '{4'h9, 4'h7, 4'hF, 4'h8, 4'h0, 4'h3};

    always #(Period / 2) i_clk = ~i_clk;

    note_event_notation_converter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    nenc_event_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic note_event_t note_ev(input logic rest, input int pitch,
                                            input logic [1:0] acc, input int face,
                                            input int dots, input int actual,
                                            input int normal, input logic bar);
        note_event_t ev;
        ev.is_rest       = rest;
        ev.pitch         = PitchW'(pitch);
        ev.accidental    = acc;
        ev.face          = FaceW'(face);
        ev.dots          = 2'(dots);
        ev.actual        = RatioW'(actual);
        ev.normal        = RatioW'(normal);
        ev.measure_start = bar;
        return ev;
    endfunction

    // Mostly well-formed tuplet groups with random content, with some noise mixed in.
    function automatic note_event_t random_event();
        note_event_t ev;
        if ($urandom_range(0, 9) == 0)
            return note_event_t'(33'({$urandom(), $urandom()}));
        ev.is_rest = ($urandom_range(0, 6) == 0);
        ev.pitch   = PitchW'($urandom_range(0, 127));
        case ($urandom_range(0, 7))
            0, 1, 2, 3: ev.accidental = AccNone;
            4, 5:       ev.accidental = AccFlat;
            6:          ev.accidental = AccOther;
            default:    ev.accidental = AccOtherHigh;
        endcase
        if ($urandom_range(0, 19) == 0)
            ev.face = FaceW'($urandom_range(9, 16));
        else
            ev.face = FaceW'($urandom_range(1, 8));
        ev.dots          = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
        ev.measure_start = ($urandom_range(0, 15) == 0);
        if (group_left == 0 && $urandom_range(0, 2) == 0) begin
            group_actual = ($urandom_range(0, 15) == 0) ? RatioW'($urandom_range(9, 255))
                                                        : RatioW'($urandom_range(2, 7));
            group_normal = RatioW'($urandom_range(1, group_actual));
            group_face   = FaceW'($urandom_range(2, 7));
            group_left   = $urandom_range(1, (group_actual > 18) ? 20 : group_actual + 2);
            ev.measure_start = ev.measure_start | ($urandom_range(0, 1) == 1);
        end
        if (group_left != 0) begin
            group_left--;
            ev.actual = group_actual;
            ev.normal = group_normal;
            if ($urandom_range(0, 4) != 0)
                ev.face = group_face;
        end else begin
            case ($urandom_range(0, 3))
                0:       begin ev.actual = '0; ev.normal = RatioW'($urandom_range(0, 255)); end
                1:       begin ev.actual = RatioW'($urandom_range(0, 255)); ev.normal = '0; end
                default: begin ev.actual = '0; ev.normal = '0; end
            endcase
        end
        return ev;
    endfunction

    // Offers one event until it is taken, then perhaps leaves a gap.
    task automatic offer_event(input note_event_t ev);
        s_axis_tdata  <= {1'b0, ev.normal, ev.actual, ev.dots, ev.face, ev.accidental,
                          ev.pitch};
        s_axis_tuser  <= {ev.measure_start, ev.is_rest};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        @(posedge i_clk);
        while (outstanding != 0 && waited < DrainLimit) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic write_key(input logic [KeyW-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: random stalls, one long hold-off on request, none in the last phase.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        // Extremes of pitch, accidental codes, rests and unknown faces.
        directed_events.push_back(note_ev(0, 0, AccNone, 1, 0, 0, 0, 1));
        directed_events.push_back(note_ev(0, 127, AccNone, 8, 3, 0, 0, 0));
        directed_events.push_back(note_ev(0, 127, AccFlat, 8, 3, 0, 0, 0));
        directed_events.push_back(note_ev(0, 60, AccFlat, 3, 0, 0, 0, 0));
        directed_events.push_back(note_ev(0, 61, AccNone, 3, 1, 0, 0, 0));
        directed_events.push_back(note_ev(0, 61, AccFlat, 3, 2, 0, 0, 0));
        directed_events.push_back(note_ev(0, 70, AccOther, 4, 0, 0, 0, 0));
        directed_events.push_back(note_ev(0, 71, AccOtherHigh, 4, 0, 0, 0, 0));
        directed_events.push_back(note_ev(1, 127, AccFlat, 2, 0, 0, 0, 0));
        directed_events.push_back(note_ev(0, 64, AccNone, 0, 1, 0, 0, 0));
        directed_events.push_back(note_ev(0, 64, AccNone, 15, 3, 0, 0, 0));
        directed_events.push_back(note_ev(0, 50, AccNone, 5, 1, 0, 0, 0));
        directed_events.push_back(note_ev(0, 50, AccNone, 6, 2, 0, 0, 0));
        directed_events.push_back(note_ev(0, 50, AccNone, 7, 3, 0, 0, 0));
        // A plain triplet: start, middle, stop.
        directed_events.push_back(note_ev(0, 62, AccNone, 4, 0, 3, 2, 1));
        directed_events.push_back(note_ev(0, 62, AccNone, 4, 0, 3, 2, 0));
        directed_events.push_back(note_ev(0, 62, AccNone, 4, 0, 3, 2, 0));
        // Half a tuplet ratio zero.
        directed_events.push_back(note_ev(0, 62, AccNone, 4, 0, 3, 0, 0));
        directed_events.push_back(note_ev(0, 62, AccNone, 4, 0, 0, 2, 0));
        // Extreme ratios and faces moving the tuplet unit both ways.
        directed_events.push_back(note_ev(0, 72, AccNone, 1, 3, 255, 1, 1));
        directed_events.push_back(note_ev(0, 72, AccNone, 8, 3, 255, 255, 0));
        directed_events.push_back(note_ev(0, 72, AccNone, 1, 0, 1, 255, 0));
        directed_events.push_back(note_ev(0, 72, AccNone, 1, 3, 1, 255, 1));
        directed_events.push_back(note_ev(0, 72, AccNone, 15, 0, 1, 255, 0));
        directed_events.push_back(note_ev(0, 72, AccNone, 0, 0, 2, 1, 1));
        directed_events.push_back(note_ev(0, 72, AccNone, 15, 0, 2, 1, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed events run with the key signature left at its reset value.
        foreach (directed_events[i])
            offer_event(directed_events[i]);
        s_axis_tvalid <= 1'b0;
        drain_results();

        for (int ph = 0; ph < Phases; ph++) begin
            write_key((ph == Phases - 2) ? KeyW'($urandom_range(0, 15)) : key_plan[ph]);
            calm = (ph == Phases - 1);
            if (ph == 1)
                hold_off = 1'b1;
            repeat (PhaseEvents) offer_event(random_event());
            s_axis_tvalid <= 1'b0;
            drain_results();
        end

        repeat (SettleCycles) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** note_event_notation_converter_unit: PASSED **");
        end else begin
            $display("** note_event_notation_converter_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(TimeoutNs);
        $display("** note_event_notation_converter_unit: FAILED **");
        $finish;
    end

endmodule
